// ===== sv/por_pkg.sv =====
// ----------------------------------------------------------------------------
// por_pkg: shared types and constants for the priority order repair unit
// Beat layouts of the load and result channels and the register reset value.
// ----------------------------------------------------------------------------
package por_pkg;

    localparam int REQ_W  = 8;
    localparam int RANK_W = 4;
    localparam int SLOT_W = 4;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RESET = 5'd14;

    typedef struct packed {
        logic [REQ_W-1:0] requested_rank;
        logic             rank_present;
    } t_in_beat;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_number;
        logic [RANK_W-1:0] final_rank;
        logic              was_filled;
        logic              last_of_run;
    } t_out_beat;

endpackage

// ===== sv/priority_order_repair_unit.sv =====
// ----------------------------------------------------------------------------
// priority_order_repair_unit: repairs requested slot ranks into a permutation
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------
//   load    | in        | i_in_valid / o_in_stall   | i_in_data  (t_in_beat)
//   result  | out       | o_out_valid / i_out_stall | o_out_data (t_out_beat)
//   config  | in        | i_cfg_we                  | i_cfg_data (5 bits)
//
// After the last active slot is loaded, each slot passes through a rank store
// read, a decide step and a send step, and its beat waits in send on stall;
// while deciding, the free-rank pointer steps past taken ranks one rank a
// cycle, at most N steps in a run.
// Reset is synchronous and active low; it clears the run and sets 14 slots.
// o_in_stall is high from the last load beat until the final result is taken.
// ----------------------------------------------------------------------------
module priority_order_repair_unit #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [por_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  por_pkg::t_in_beat        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output por_pkg::t_out_beat       o_out_data
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_READ = 4'b0010,
        ST_FIND = 4'b0100,
        ST_SEND = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [por_pkg::CFG_W-1:0]  r_active, n_active;
    logic [CW-1:0]              r_load_cnt, n_load_cnt;
    logic [MAX_SLOTS-1:0]       r_kept_valid, n_kept_valid;
    logic [MAX_SLOTS-1:0]       r_rank_used, n_rank_used;
    logic [IW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_next, n_next;
    por_pkg::t_out_beat         r_out, n_out;

    logic [por_pkg::RANK_W-1:0] r_kept_rank_mem [MAX_SLOTS];
    logic [por_pkg::RANK_W-1:0] r_rd_rank;
    logic                       mem_we;
    logic [IW-1:0]              mem_waddr;

    logic [CW-1:0]              total;
    logic                       in_acc;
    logic                       req_ok;
    logic [IW-1:0]              req_idx;
    logic [IW-1:0]              slot_idx;
    logic                       keep;
    logic                       next_ok;
    logic [IW-1:0]              next_idx;
    logic                       is_last;

    // clamp the slot count to 1 .. MAX_SLOTS
    always_comb begin
        if (r_active == '0) begin
            total = CW'(1);
        end else if (int'(r_active) > MAX_SLOTS) begin
            total = CW'(MAX_SLOTS);
        end else begin
            total = CW'(r_active);
        end
    end

    assign in_acc   = i_in_valid && !o_in_stall;
    assign req_ok   = i_in_data.rank_present && (int'(i_in_data.requested_rank) < int'(total));
    assign req_idx  = i_in_data.requested_rank[IW-1:0];
    assign slot_idx = r_load_cnt[IW-1:0];
    assign keep     = req_ok && !r_rank_used[req_idx];
    assign next_ok  = r_next < total;
    assign next_idx = r_next[IW-1:0];
    assign is_last  = (CW'(r_idx) + CW'(1)) == total;

    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_load_cnt   = r_load_cnt;
        n_kept_valid = r_kept_valid;
        n_rank_used  = r_rank_used;
        n_idx        = r_idx;
        n_next       = r_next;
        n_out        = r_out;
        mem_we       = 1'b0;
        mem_waddr    = slot_idx;

        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    n_kept_valid[slot_idx] = keep;
                    if (keep) begin
                        n_rank_used[req_idx] = 1'b1;
                    end
                    mem_we     = keep;
                    n_load_cnt = r_load_cnt + CW'(1);
                    if (n_load_cnt >= total) begin
                        n_state = ST_READ;
                        n_idx   = '0;
                        n_next  = '0;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_FIND;
            end
            ST_FIND: begin
                n_out.slot_number = por_pkg::SLOT_W'(r_idx);
                n_out.last_of_run = is_last;
                if (r_kept_valid[r_idx]) begin
                    n_out.final_rank = r_rd_rank;
                    n_out.was_filled = 1'b0;
                    n_state          = ST_SEND;
                end else if (next_ok && r_rank_used[next_idx]) begin
                    // step past a taken rank
                    n_next = r_next + CW'(1);
                end else begin
                    n_out.final_rank = next_ok ? por_pkg::RANK_W'(r_next) : '0;
                    n_out.was_filled = 1'b1;
                    if (next_ok) begin
                        n_rank_used[next_idx] = 1'b1;
                    end
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (!i_out_stall) begin
                    if (r_out.last_of_run) begin
                        n_load_cnt   = '0;
                        n_kept_valid = '0;
                        n_rank_used  = '0;
                        n_state      = ST_LOAD;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        // a register write abandons the run
        if (i_cfg_we) begin
            n_active     = i_cfg_data;
            n_load_cnt   = '0;
            n_kept_valid = '0;
            n_rank_used  = '0;
            n_state      = ST_LOAD;
            mem_we       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_active     <= por_pkg::ACTIVE_SLOTS_RESET;
            r_load_cnt   <= '0;
            r_kept_valid <= '0;
            r_rank_used  <= '0;
            r_idx        <= '0;
            r_next       <= '0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_load_cnt   <= n_load_cnt;
            r_kept_valid <= n_kept_valid;
            r_rank_used  <= n_rank_used;
            r_idx        <= n_idx;
            r_next       <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_kept_rank_mem[mem_waddr] <= por_pkg::RANK_W'(i_in_data.requested_rank);
        end
        r_rd_rank <= r_kept_rank_mem[r_idx];
    end

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_out_valid = (r_state == ST_SEND);
    assign o_out_data  = r_out;

    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_valid && !o_in_stall && o_out_valid))
        else $error("load beat taken while a result is pending");

    a_load_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_load_cnt < total))
        else $error("load count reached the slot count while loading");

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_of_run)
        |=> (r_rank_used == '0 && r_kept_valid == '0 && r_load_cnt == '0))
        else $error("run state not cleared after final result");

    a_perm_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEND && r_out.last_of_run)
        |-> ($countones(r_rank_used) == int'(total)))
        else $error("final result leaves ranks unassigned");

endmodule

// ===== tb/priority_order_repair_unit_tb.sv =====
// ----------------------------------------------------------------------------
// priority_order_repair_unit_tb: self-checking bench for the rank repair unit
// Loads runs of slot requests (directed corner cases, then random runs with
// duplicates, unset and out-of-range ranks) under random gaps and output
// stalls, across several slot counts. A scoreboard predicts each repaired
// permutation and checks every result beat in order.
// ----------------------------------------------------------------------------
module priority_order_repair_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SLOTS  = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int ITEM_GOAL  = 330;

    class rank_repair_board;
        logic [por_pkg::RANK_W-1:0] kept_rank [MAX_SLOTS];
        bit                         kept_valid[MAX_SLOTS];
        bit                         rank_used [MAX_SLOTS];
        int unsigned                load_count;
        logic [por_pkg::CFG_W-1:0]  active_slots;
        por_pkg::t_out_beat         expected_ranks[$];
        int                         errors;

        function new();
            foreach (kept_rank[i]) kept_rank[i] = '0;
            clear_run();
            active_slots = por_pkg::ACTIVE_SLOTS_RESET;
            errors       = 0;
        endfunction

        function void clear_run();
            foreach (kept_valid[i]) begin
                kept_valid[i] = 1'b0;
                rank_used[i]  = 1'b0;
            end
            load_count = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        function int unsigned slot_total();
            int unsigned n;
            n = active_slots;
            if (n < 1) n = 1;
            if (n > MAX_SLOTS) n = MAX_SLOTS;
            return n;
        endfunction

        // a register write drops any run in progress
        function void set_slots(logic [por_pkg::CFG_W-1:0] value);
            active_slots = value;
            clear_run();
        endfunction

        function int pending();
            return expected_ranks.size();
        endfunction

        function void note_load(por_pkg::t_in_beat b);
            int unsigned        total, slot, next, rank;
            bit                 filled;
            por_pkg::t_out_beat beat;
            total = slot_total();
            slot  = load_count;
            if (slot >= total) begin
                clear_run();
                slot = 0;
            end
            if (b.rank_present && b.requested_rank < total &&
                !rank_used[b.requested_rank[por_pkg::RANK_W-1:0]]) begin
                kept_rank[slot]  = b.requested_rank[por_pkg::RANK_W-1:0];
                kept_valid[slot] = 1'b1;
                rank_used[b.requested_rank[por_pkg::RANK_W-1:0]] = 1'b1;
            end else begin
                kept_valid[slot] = 1'b0;
            end
            load_count = slot + 1;
            if (load_count < total) return;

            // hand out the smallest unused ranks to unkept slots, in slot order
            next = 0;
            for (int i = 0; i < total; i++) begin
                if (kept_valid[i]) begin
                    rank   = kept_rank[i];
                    filled = 1'b0;
                end else begin
                    while (next < total && rank_used[next]) next++;
                    rank = (next < total) ? next : 0;
                    if (next < total) rank_used[next] = 1'b1;
                    filled = 1'b1;
                end
                beat.slot_number = por_pkg::SLOT_W'(i);
                beat.final_rank  = por_pkg::RANK_W'(rank);
                beat.was_filled  = filled;
                beat.last_of_run = (i + 1 == total);
                expected_ranks.push_back(beat);
            end
            clear_run();
        endfunction

        task check_result(por_pkg::t_out_beat got);
            por_pkg::t_out_beat want;
            if (expected_ranks.size() == 0) begin
                report($sformatf("unexpected result beat slot=%0d rank=%0d",
                                 got.slot_number, got.final_rank));
                return;
            end
            want = expected_ranks.pop_front();
            if (got.slot_number !== want.slot_number || got.final_rank !== want.final_rank ||
                got.was_filled !== want.was_filled || got.last_of_run !== want.last_of_run)
                report($sformatf("slot/rank/filled/last got %0d/%0d/%b/%b want %0d/%0d/%b/%b",
                                 got.slot_number, got.final_rank, got.was_filled,
                                 got.last_of_run, want.slot_number, want.final_rank,
                                 want.was_filled, want.last_of_run));
        endtask

        task finish_check();
            if (expected_ranks.size() != 0)
                report($sformatf("%0d result beats never arrived", expected_ranks.size()));
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [por_pkg::CFG_W-1:0] cfg_data;
    logic                      in_valid;
    logic                      o_in_stall;
    por_pkg::t_in_beat         in_data;
    logic                      o_out_valid;
    logic                      out_stall;
    por_pkg::t_out_beat        o_out_data;

    rank_repair_board board = new();
    bit               calm;
    int               loads_sent;
    int               quiet;

    priority_order_repair_unit #(
        .MAX_SLOTS(MAX_SLOTS)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // result side back-pressure
    initial begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else begin
                out_stall = 1'b0;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        bit moved;
        moved = 1'b0;
        if (!rst_n) begin
            quiet = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                board.check_result(o_out_data);
                moved = 1'b1;
            end
            if (cfg_we) begin
                board.set_slots(cfg_data);
                moved = 1'b1;
            end
            if (in_valid && !o_in_stall) begin
                board.note_load(in_data);
                moved = 1'b1;
            end
            if (moved) begin
                quiet = 0;
            end else if (quiet + 1 >= IDLE_LIMIT) begin
                $display("** priority_order_repair_unit: FAILED **");
                $finish;
            end else begin
                quiet++;
            end
        end
    end

    task automatic send_load(input logic [por_pkg::REQ_W-1:0] rank, input logic present);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.requested_rank = rank;
        in_data.rank_present   = present;
        in_valid               = 1'b1;
        do @(posedge clk); while (o_in_stall);
        @(negedge clk);
        loads_sent++;
    endtask

    // drain every pending result, then let the block settle
    task automatic settle(input int pause);
        in_valid = 1'b0;
        while (board.pending() != 0) @(negedge clk);
        repeat (pause) @(negedge clk);
    endtask

    task automatic write_slots(input logic [por_pkg::CFG_W-1:0] value);
        cfg_data = value;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    // mostly a shuffled permutation, salted with clashes and unset requests
    task automatic send_run(input int unsigned total, input int unsigned count);
        logic [por_pkg::REQ_W-1:0] perm[MAX_SLOTS];
        logic [por_pkg::REQ_W-1:0] swap;
        int unsigned               j, pick;
        for (int k = 0; k < MAX_SLOTS; k++) perm[k] = por_pkg::REQ_W'(k);
        for (int k = int'(total) - 1; k > 0; k--) begin
            j       = $urandom_range(0, k);
            swap    = perm[k];
            perm[k] = perm[j];
            perm[j] = swap;
        end
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                send_load(perm[k], 1'b1);
            else if (pick < 7)
                send_load(por_pkg::REQ_W'($urandom_range(0, total - 1)), 1'b1);
            else if (pick == 7)
                send_load(por_pkg::REQ_W'($urandom), 1'b0);
            else if (pick == 8)
                send_load(por_pkg::REQ_W'($urandom_range(total, 255)), 1'b1);
            else
                send_load(por_pkg::REQ_W'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int unsigned               total, runs;
        int                        pick;
        logic [por_pkg::CFG_W-1:0] value;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        calm       = 1'b0;
        loads_sent = 0;
        quiet      = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting of 14 slots
        send_load(8'd13, 1'b1);
        send_load(8'd13, 1'b1);     // clash: first claimant keeps it
        send_load(8'd0, 1'b1);
        send_load(8'd14, 1'b1);     // equal to the slot count, so unset
        send_load(8'd255, 1'b1);
        send_load(8'd5, 1'b0);      // not present: rank ignored
        send_load(8'd5, 1'b1);
        for (int k = 0; k < 7; k++) send_load(por_pkg::REQ_W'(k * 2), 1'(k));

        settle(4);
        write_slots(5'd1);
        send_load(8'd0, 1'b1);
        send_load(8'd1, 1'b1);
        settle(4);
        write_slots(5'd0);          // zero slots behave as one
        send_load(8'd0, 1'b0);
        settle(4);
        write_slots(5'd31);         // clamps to the maximum
        send_load(8'd15, 1'b1);
        send_load(8'd15, 1'b1);
        send_load(8'd16, 1'b1);
        settle(4);
        write_slots(5'd16);         // abandons the partial run

        while (loads_sent < ITEM_GOAL) begin
            settle(4);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       value = 5'd0;
                1:       value = 5'd1;
                2:       value = 5'd16;
                3:       value = 5'd31;
                4:       value = por_pkg::CFG_W'($urandom_range(17, 30));
                default: value = por_pkg::CFG_W'($urandom_range(2, 15));
            endcase
            write_slots(value);
            calm  = ($urandom_range(0, 3) == 0);
            total = board.slot_total();
            runs  = (total <= 4) ? $urandom_range(2, 6) : $urandom_range(1, 3);
            repeat (runs) send_run(total, total);
            // leave a run unfinished for the next write to drop
            if (total > 1 && $urandom_range(0, 4) == 0)
                send_run(total, $urandom_range(1, total - 1));
        end

        settle(60);
        board.finish_check();
        if (board.errors == 0) begin
            $display("** priority_order_repair_unit: PASSED **");
        end else begin
            $display("** priority_order_repair_unit: FAILED **");
        end
        $finish;
    end

endmodule
